// ----- src/ftarm_pkg.sv -----
// shared constants for the frame time average and rate meter
package ftarm_pkg;

    // window depth and fixed field widths
    localparam int WIN_DEPTH = 64;
    localparam int TS_W      = 32;
    localparam int AVG_W     = 40;
    localparam int RATE_W    = 16;
    localparam int FRAC_W    = 8;

    // widths that follow from the window depth
    localparam int FILL_W  = $clog2(WIN_DEPTH + 1);
    localparam int PTR_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int SUM_W   = TS_W + PTR_W;
    localparam int DIV_W   = SUM_W + FRAC_W;
    localparam int DIFF_W  = AVG_W + 1;
    localparam int DELTA_W = TS_W + 2;
    localparam int IVL_W   = TS_W + 1;

    // acceptance span in q8 and the rate interval in ms
    localparam int ACCEPT_SPAN_Q8 = 1000 << FRAC_W;
    localparam int INTERVAL_MS    = 1000;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

endpackage

// ----- src/ftarm_if.sv -----
// valid/ready channel interfaces for timestamp beats and result beats
interface ftarm_in_if;
    import ftarm_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic [TS_W-1:0] timestamp_ms;

    modport source (output valid, output kind, output timestamp_ms, input ready);
    modport sink   (input valid, input kind, input timestamp_ms, output ready);
endinterface

interface ftarm_out_if;
    import ftarm_pkg::*;

    logic              valid;
    logic              ready;
    logic [TS_W-1:0]   elapsed_ms;
    logic              sample_accepted;
    logic [AVG_W-1:0]  average_frame_time;
    logic [RATE_W-1:0] frame_rate;

    modport source (output valid, output elapsed_ms, output sample_accepted,
                    output average_frame_time, output frame_rate, input ready);
    modport sink   (input valid, input elapsed_ms, input sample_accepted,
                    input average_frame_time, input frame_rate, output ready);
endinterface

// ----- src/ftarm_div.sv -----
// bit-serial restoring divider: window sum in q8 over the fill count
module ftarm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ftarm_pkg::DIV_W-1:0]  dividend,
    input  logic [ftarm_pkg::FILL_W-1:0] divisor,
    output logic                         done,
    output logic [ftarm_pkg::DIV_W-1:0]  quotient
);
    import ftarm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [FILL_W-1:0] dvs_reg, dvs_next;
    logic [FILL_W:0]   trial;
    logic              fits;

    // one quotient bit per cycle, dividend shifts out msb first
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? FILL_W'(trial - {1'b0, dvs_reg}) : FILL_W'(trial);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/frame_time_average_and_rate_meter_unit.sv -----
// frame time average and frame rate meter, top level
//
//   channel  side   beat contents
//   frames   sink   kind, timestamp_ms
//   stats    source elapsed_ms, sample_accepted, average_frame_time, frame_rate
//
// a start beat goes from the idle state straight to the done state; a tick
// passes through the check, push, divgo and divwait states before done, and in
// divwait it waits on the bit-serial divider that makes one quotient bit a cycle.
// one item is in work at a time; the result register lets a new beat enter
// while the previous result waits on stats.ready, and a finished item waits in
// the done state, with frames.ready low, until the result register is free.
// rst_n clears all control and running state; the window memory needs no clear.
module frame_time_average_and_rate_meter_unit (
    input  logic       clk,
    input  logic       rst_n,
    ftarm_in_if.sink   frames,
    ftarm_out_if.source stats
);
    import ftarm_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_PUSH    = 3'd2;
    localparam logic [2:0] S_DIVGO   = 3'd3;
    localparam logic [2:0] S_DIVWAIT = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    localparam logic signed [DIFF_W-1:0] SPAN_POS = DIFF_W'(ACCEPT_SPAN_Q8);
    localparam logic signed [DIFF_W-1:0] SPAN_NEG = -SPAN_POS;

    // control and running state
    logic [2:0]         state_reg, state_next;
    logic [TS_W-1:0]    last_reg, last_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic [RATE_W-1:0]  frames_reg, frames_next;
    logic [IVL_W-1:0]   ivl_reg, ivl_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic               ovalid_reg, ovalid_next;

    // per-item working registers
    logic [TS_W-1:0]           elapsed_reg, elapsed_next;
    logic                      acc_reg, acc_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;

    // result register
    logic [TS_W-1:0]    o_elapsed_reg;
    logic               o_acc_reg;
    logic [AVG_W-1:0]   o_avg_reg;
    logic [RATE_W-1:0]  o_rate_reg;

    // window memory
    logic [TS_W-1:0]    win_mem [WIN_DEPTH];
    logic [TS_W-1:0]    rd_data_reg;
    logic               win_we;

    logic               in_fire;
    logic               out_load;
    logic               full;
    logic               accept;
    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;

    assign in_fire  = frames.valid && frames.ready;
    assign full     = (fill_reg == FILL_W'(WIN_DEPTH));
    assign accept   = (diff_reg < SPAN_POS) && (diff_reg > SPAN_NEG);
    assign out_load = (state_reg == S_DONE) && (!ovalid_reg || stats.ready);
    assign div_start = (state_reg == S_DIVGO);
    assign win_we   = (state_reg == S_PUSH) && accept;

    // window sum in q8 divided by the fill count
    ftarm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, {FRAC_W{1'b0}}}),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer and state updates
    always_comb
    begin
        state_next   = state_reg;
        last_next    = last_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        frames_next  = frames_reg;
        ivl_next     = ivl_reg;
        rate_next    = rate_reg;
        elapsed_next = elapsed_reg;
        acc_next     = acc_reg;
        diff_next    = diff_reg;
        delta_next   = delta_reg;
        ovalid_next  = ovalid_reg;
        if (stats.valid && stats.ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = frames.timestamp_ms;
                    acc_next  = 1'b0;
                    if (frames.kind == KIND_TICK)
                    begin
                        elapsed_next = frames.timestamp_ms - last_reg;
                        state_next   = S_CHECK;
                    end
                    else
                    begin
                        elapsed_next = '0;
                        state_next   = S_DONE;
                    end
                end
            end
            S_CHECK:
            begin
                // distance to the average, and the sum change if pushed
                diff_next  = $signed({1'b0, elapsed_reg, {FRAC_W{1'b0}}})
                           - $signed({1'b0, avg_reg});
                delta_next = $signed({2'b00, elapsed_reg})
                           - $signed({2'b00, (full ? rd_data_reg : {TS_W{1'b0}})});
                if (frames_reg != {RATE_W{1'b1}})
                begin
                    frames_next = frames_reg + 1'b1;
                end
                ivl_next   = ivl_reg + {1'b0, elapsed_reg};
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                acc_next = accept;
                if (accept)
                begin
                    sum_next = sum_reg + SUM_W'(delta_reg);
                    if (!full)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    ptr_next = (ptr_reg == PTR_W'(WIN_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                end
                // close the rate interval past one second
                if (ivl_reg > IVL_W'(INTERVAL_MS))
                begin
                    rate_next   = frames_reg;
                    frames_next = '0;
                    ivl_next    = '0;
                end
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (div_done)
                begin
                    avg_next   = (fill_reg == '0) ? '0 : div_quo[AVG_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and running state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            last_reg   <= '0;
            fill_reg   <= '0;
            ptr_reg    <= '0;
            sum_reg    <= '0;
            avg_reg    <= '0;
            frames_reg <= '0;
            ivl_reg    <= '0;
            rate_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            fill_reg   <= fill_next;
            ptr_reg    <= ptr_next;
            sum_reg    <= sum_next;
            avg_reg    <= avg_next;
            frames_reg <= frames_next;
            ivl_reg    <= ivl_next;
            rate_reg   <= rate_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        acc_reg     <= acc_next;
        diff_reg    <= diff_next;
        delta_reg   <= delta_next;
        if (out_load)
        begin
            o_elapsed_reg <= elapsed_reg;
            o_acc_reg     <= acc_reg;
            o_avg_reg     <= avg_reg;
            o_rate_reg    <= rate_reg;
        end
    end

    // window memory: newest written at the pointer, oldest read from it
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[ptr_reg] <= elapsed_reg;
        end
        rd_data_reg <= win_mem[ptr_reg];
    end

    // ports
    assign frames.ready             = (state_reg == S_IDLE);
    assign stats.valid              = ovalid_reg;
    assign stats.elapsed_ms         = o_elapsed_reg;
    assign stats.sample_accepted    = o_acc_reg;
    assign stats.average_frame_time = o_avg_reg;
    assign stats.frame_rate         = o_rate_reg;

    // fill count never passes the window depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WIN_DEPTH))
        else $error("window fill above depth");

    // an open interval never holds more than one second between items
    a_interval_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (ivl_reg <= IVL_W'(INTERVAL_MS)))
        else $error("rate interval not closed");

    // an accepted sample leaves a nonempty window
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (stats.valid && stats.sample_accepted) |-> (fill_reg != '0))
        else $error("sample accepted with empty window");

    // a start beat goes straight to the result stage
    a_start_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && frames.kind == KIND_START) |=> (state_reg == S_DONE))
        else $error("start beat took the tick path");

endmodule

// ----- sim/tb_top.sv -----
// testbench for the frame time average and rate meter: random beats checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ftarm_pkg::*;

    // one timestamp beat and one stats beat
    typedef struct packed {
        logic            kind;
        logic [TS_W-1:0] timestamp_ms;
    } frame_beat_t;

    typedef struct packed {
        logic [TS_W-1:0]   elapsed_ms;
        logic              sample_accepted;
        logic [AVG_W-1:0]  average_frame_time;
        logic [RATE_W-1:0] frame_rate;
    } frame_stats_t;

    localparam int RANDOM_BEATS = 700;
    localparam int DRAIN_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n;

    ftarm_in_if  frames ();
    ftarm_out_if stats ();

    frame_time_average_and_rate_meter_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .frames (frames),
        .stats  (stats)
    );

    // clock
    always #5 clk = ~clk;

    // beats waiting to be sent and stats waiting to arrive
    frame_beat_t  frame_q[$];
    frame_stats_t expected_stats_q[$];

    int          mismatch_count = 0;
    int          beats_queued   = 0;
    int          stats_seen     = 0;
    int          gap_left;
    int          stall_left;
    bit          steady_run     = 1'b0;
    logic [31:0] gen_ts         = '0;

    // meter state as predicted
    logic [TS_W-1:0]   m_last;
    logic [TS_W-1:0]   m_window [WIN_DEPTH];
    logic [FILL_W-1:0] m_fill;
    logic [SUM_W-1:0]  m_sum;
    logic [AVG_W-1:0]  m_avg;
    logic [RATE_W-1:0] m_frames;
    logic [IVL_W-1:0]  m_interval;
    logic [RATE_W-1:0] m_rate;

    // advance the predicted meter by one beat and return the stats it yields
    function automatic frame_stats_t advance_meter(logic kind, logic [TS_W-1:0] ts);
        frame_stats_t            res;
        logic [TS_W-1:0]         el;
        logic [63:0]             e_q8;
        logic [63:0]             gap_q8;
        logic [SUM_W+FRAC_W-1:0] quot;
        int                      i;
        res = '0;
        if (kind == KIND_TICK)
        begin
            el     = ts - m_last;
            m_last = ts;
            e_q8   = {24'b0, el, 8'b0};
            gap_q8 = (e_q8 >= {24'b0, m_avg}) ? e_q8 - {24'b0, m_avg}
                                              : {24'b0, m_avg} - e_q8;
            // window push, oldest entry drops out once full
            if (gap_q8 < 64'(ACCEPT_SPAN_Q8))
            begin
                if (m_fill >= FILL_W'(WIN_DEPTH))
                    m_sum = m_sum - SUM_W'(m_window[WIN_DEPTH-1]);
                else
                    m_fill = m_fill + 1'b1;
                for (i = WIN_DEPTH - 1; i > 0; i--)
                    m_window[i] = m_window[i-1];
                m_window[0] = el;
                m_sum = m_sum + SUM_W'(el);
                res.sample_accepted = 1'b1;
            end
            // saturating frame count over a one second interval
            if (m_frames != '1)
                m_frames = m_frames + 1'b1;
            m_interval = m_interval + IVL_W'(el);
            if (m_interval > IVL_W'(INTERVAL_MS))
            begin
                m_rate     = m_frames;
                m_frames   = '0;
                m_interval = '0;
            end
            if (m_fill != '0)
            begin
                quot  = {m_sum, 8'b0} / m_fill;
                m_avg = quot[AVG_W-1:0];
            end
            else
            begin
                m_avg = '0;
            end
            res.elapsed_ms = el;
        end
        else
        begin
            m_last = ts;
        end
        res.average_frame_time = m_avg;
        res.frame_rate         = m_rate;
        return res;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 99)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 200);
    endfunction

    // sender: holds a beat until accepted, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t nxt;
        if (!rst_n)
        begin
            frames.valid <= 1'b0;
            gap_left     <= 0;
            m_last       = '0;
            m_fill       = '0;
            m_sum        = '0;
            m_avg        = '0;
            m_frames     = '0;
            m_interval   = '0;
            m_rate       = '0;
        end
        else
        begin
            if (frames.valid && frames.ready)
                expected_stats_q.push_back(advance_meter(frames.kind, frames.timestamp_ms));
            if (!(frames.valid && !frames.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    frames.valid <= 1'b0;
                end
                else if (frame_q.size() > 0)
                begin
                    nxt = frame_q.pop_front();
                    frames.valid        <= 1'b1;
                    frames.kind         <= nxt.kind;
                    frames.timestamp_ms <= nxt.timestamp_ms;
                    gap_left            <= steady_run ? 0 : pick_gap();
                end
                else
                begin
                    frames.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, compares each stats beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        frame_stats_t got;
        frame_stats_t want;
        if (!rst_n)
        begin
            stats.ready <= 1'b0;
            stall_left  <= 0;
        end
        else
        begin
            if (stats.valid && stats.ready)
            begin
                stats_seen++;
                got.elapsed_ms         = stats.elapsed_ms;
                got.sample_accepted    = stats.sample_accepted;
                got.average_frame_time = stats.average_frame_time;
                got.frame_rate         = stats.frame_rate;
                if (expected_stats_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: stats beat with none expected: %s",
                                 $realtime,
                                 $sformatf("el=%0d acc=%0b avg=%h rate=%0d",
                                           got.elapsed_ms, got.sample_accepted,
                                           got.average_frame_time, got.frame_rate));
                end
                else
                begin
                    want = expected_stats_q.pop_front();
                    if (got.elapsed_ms !== want.elapsed_ms
                        || got.sample_accepted !== want.sample_accepted
                        || got.average_frame_time !== want.average_frame_time
                        || got.frame_rate !== want.frame_rate)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch exp %s, got %s", $realtime,
                                     $sformatf("el=%0d acc=%0b avg=%h rate=%0d",
                                               want.elapsed_ms, want.sample_accepted,
                                               want.average_frame_time, want.frame_rate),
                                     $sformatf("el=%0d acc=%0b avg=%h rate=%0d",
                                               got.elapsed_ms, got.sample_accepted,
                                               got.average_frame_time, got.frame_rate));
                    end
                end
            end
            if (stall_left > 0)
            begin
                stats.ready <= 1'b0;
                stall_left  <= stall_left - 1;
            end
            else if (!steady_run && $urandom_range(0, 7) == 0)
            begin
                stats.ready <= 1'b0;
                stall_left  <= pick_gap();
            end
            else
            begin
                stats.ready <= 1'b1;
            end
        end
    end

    // stimulus helpers
    task automatic send_start(logic [31:0] ts);
        frame_q.push_back('{kind: KIND_START, timestamp_ms: ts});
        gen_ts = ts;
        beats_queued++;
    endtask

    task automatic send_tick_at(logic [31:0] ts);
        frame_q.push_back('{kind: KIND_TICK, timestamp_ms: ts});
        gen_ts = ts;
        beats_queued++;
    endtask

    task automatic send_tick_after(logic [31:0] el);
        send_tick_at(gen_ts + el);
    endtask

    // hold the sender until every queued beat has its stats back
    task automatic wait_all_drained();
        while (stats_seen < beats_queued)
            @(posedge clk);
    endtask

    // aim a tick at the edges of the acceptance band around the current average
    task automatic probe_accept_edge();
        logic [63:0] avg_q8;
        logic [63:0] hi_ms;
        logic [63:0] lo_ms;
        logic [63:0] pick;
        wait_all_drained();
        avg_q8 = {24'b0, m_avg};
        hi_ms  = (avg_q8 + 64'(ACCEPT_SPAN_Q8) - 64'd1) >> FRAC_W;
        lo_ms  = (avg_q8 >= 64'(ACCEPT_SPAN_Q8))
               ? ((avg_q8 - 64'(ACCEPT_SPAN_Q8)) >> FRAC_W) + 64'd1 : 64'd0;
        case ($urandom_range(0, 3))
            0:       pick = hi_ms;
            1:       pick = hi_ms + 64'd1;
            2:       pick = lo_ms;
            default: pick = (lo_ms > 0) ? lo_ms - 64'd1 : hi_ms + 64'd1;
        endcase
        send_tick_after(pick[31:0]);
    endtask

    // a run of ticks near one frame period
    task automatic send_burst();
        int unsigned period;
        int unsigned jit;
        int unsigned len;
        int          i;
        case ($urandom_range(0, 9))
            0:       period = $urandom_range(0, 3);
            7, 8:    period = $urandom_range(100, 900);
            9:       period = $urandom_range(950, 1100);
            default: period = $urandom_range(8, 60);
        endcase
        jit = period / 8;
        len = $urandom_range(5, 60);
        for (i = 0; i < len; i++)
            send_tick_after(period + $urandom_range(0, 2 * jit) - jit);
    endtask

    // reset, directed beats, random bursts, end check
    initial
    begin
        int i;
        rst_n               = 1'b0;
        frames.valid        = 1'b0;
        frames.kind         = KIND_START;
        frames.timestamp_ms = '0;
        stats.ready         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero elapsed, acceptance edge at a zero average, exact interval
        send_tick_at(32'd0);
        send_tick_at(32'd1000);
        send_tick_at(32'd1999);
        // wrap of the timestamp
        send_start(32'hFFFF_FFF0);
        send_tick_at(32'h0000_000C);
        // timestamp going backwards
        send_start(32'd5000);
        send_tick_at(32'd4999);
        // largest elapsed time and largest timestamp
        send_start(32'd0);
        send_tick_at(32'hFFFF_FFFF);
        // steady frames
        send_start(32'h8000_0000);
        for (i = 0; i < 10; i++)
            send_tick_after(32'd16 + (i % 2));
        send_tick_after(32'd1001);
        wait_all_drained();

        // random: mostly bursts of frames, some restarts, noise and edge probes
        while (beats_queued < RANDOM_BEATS)
        begin
            steady_run = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 99)) inside
                [0:5]:   send_start($urandom);
                [6:7]:   send_start(32'hFFFF_FF00 + $urandom_range(0, 255));
                [8:11]:  send_tick_at($urandom);
                [12:21]:
                begin
                    for (i = 0; i < 3; i++)
                        probe_accept_edge();
                end
                default: send_burst();
            endcase
        end
        steady_run = 1'b0;
        wait_all_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_stats_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- frame_time_average_and_rate_meter_unit.f -----
src/ftarm_pkg.sv
src/ftarm_if.sv
src/ftarm_div.sv
src/frame_time_average_and_rate_meter_unit.sv
sim/tb_top.sv
